// ===== src/adsr_envelope_generator_macros.svh =====
// ----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Shared property shorthands for the envelope generator RTL.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ADSR_ASSERT_IMPL(name, ck, rst_n, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ADSR_ASSERT_NEXT(name, ck, rst_n, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR package
// Payload types, register indexes, stage codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

	localparam int unsigned SR_W       = 18;
	localparam int unsigned TD_W       = 11;
	localparam int unsigned AT_W       = 16;
	localparam int unsigned RATE_W     = 10;
	localparam int unsigned SUST_W     = 7;
	localparam int unsigned ENV_W      = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 18;

	// serial multiplier consumes one multiplier bit per cycle
	localparam int unsigned MP_W = AT_W;
	// attack divisor is sample_rate * attack_time
	localparam int unsigned DEN_W = SR_W + AT_W;
	// attack dividend (1000 << 16) * tick_divider fits in 37 bits
	localparam int unsigned NUM_BASE_W = 37;

	localparam int unsigned ATK_MS    = 1000;
	localparam int unsigned ATK_SHIFT = 16;
	localparam int unsigned PERMILLE  = 1000;
	localparam int unsigned PERCENT   = 100;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDER = 1'b1;

	localparam logic [SR_W-1:0] SR_RESET = 18'd44100;
	localparam logic [TD_W-1:0] TD_RESET = 11'd32;

	localparam logic [1:0] STAGE_ATTACK  = 2'd0;
	localparam logic [1:0] STAGE_DECAY   = 2'd1;
	localparam logic [1:0] STAGE_RELEASE = 2'd2;

	typedef struct packed {
		logic              gate;
		logic [AT_W-1:0]   attack_time;
		logic [RATE_W-1:0] decay_rate;
		logic [SUST_W-1:0] sustain_percent;
		logic [RATE_W-1:0] release_rate;
	} ctl_t;

	typedef struct packed {
		logic [ENV_W-1:0] envelope;
	} env_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/adsr_chan_if.sv =====
// ----------------------------------------------------------------------------
// ADSR channel interface
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_chan_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== src/adsr_ser_mul.sv =====
// ----------------------------------------------------------------------------
// ADSR serial multiplier
// Shift-and-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_ser_mul import adsr_pkg::*; #(
	parameter int unsigned NUM_W = 37
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] mc,
	input  logic [MP_W-1:0]  mp,
	output logic             done,
	output logic [NUM_W-1:0] prod
);

	localparam int unsigned CNT_W = $clog2(MP_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MP_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] acc_q;
	logic [NUM_W-1:0] mc_q;
	logic [MP_W-1:0]  mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= mc;
			mp_q  <= mp;
		end else if (busy_q) begin
			if (mp_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[NUM_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[MP_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// ===== src/adsr_ser_div.sv =====
// ----------------------------------------------------------------------------
// ADSR serial divider
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_ser_div import adsr_pkg::*; #(
	parameter int unsigned NUM_W = 37
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] nq_q;   // dividend shifts out the top, quotient in the bottom
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (fits)
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[DEN_W-1:0];
			nq_q <= {nq_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

`default_nettype wire

// ===== src/adsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ADSR control
// Stage/level update sequencer around the serial multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adsr_envelope_generator_macros.svh"

module adsr_ctrl import adsr_pkg::*; #(
	parameter int unsigned FULL_SCALE = 65535,
	parameter int unsigned LVL_W      = $clog2(FULL_SCALE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ctl_t             in_data,
	input  logic [SR_W-1:0]  sample_rate,
	input  logic [TD_W-1:0]  tick_divider,
	input  logic             out_free,
	output logic             res_valid,
	output logic [LVL_W-1:0] res_level
);

	localparam int unsigned SUS_W = LVL_W + 1;
	localparam int unsigned SUS_N = 2 ** SUST_W;
	localparam int unsigned NUM_W =
		(LVL_W + RATE_W > NUM_BASE_W) ? LVL_W + RATE_W : NUM_BASE_W;

	localparam logic [LVL_W-1:0] FULL      = LVL_W'(FULL_SCALE);
	localparam logic [NUM_W-1:0] FULL_N    = NUM_W'(FULL_SCALE);
	localparam logic [NUM_W-1:0] ATK_SCALE = NUM_W'(ATK_MS) << ATK_SHIFT;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       stage_q;
	logic [LVL_W-1:0] lvl_q;
	logic             hold_q;
	logic [NUM_W-1:0] step_q;

	logic [SUS_W-1:0] sus_tab [SUS_N];
	logic [SUS_W-1:0] sus;
	logic [1:0]       stage_n;
	logic [LVL_W-1:0] lvl_s;
	logic             accept;
	logic             atk_zero;
	logic             dec_hold;

	logic             mul_start;
	logic [NUM_W-1:0] mul_mc;
	logic [MP_W-1:0]  mul_mp;
	logic             mul_done;
	logic [NUM_W-1:0] mul_prod;

	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;

	logic [LVL_W-1:0] atk_step;
	logic [LVL_W:0]   atk_sum;
	logic [NUM_W-1:0] drop;
	logic [LVL_W-1:0] lvl_new;

	// sustain level per percent code, worked out at elaboration
	for (genvar i = 0; i < SUS_N; i++) begin : g_sus
		assign sus_tab[i] = SUS_W'((64'(FULL_SCALE) * 64'(i)) / 64'(PERCENT));
	end

	assign sus      = sus_tab[in_data.sustain_percent];
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign atk_zero = (in_data.attack_time == '0) || (sample_rate == '0);

	always_comb begin
		stage_n = stage_q;
		lvl_s   = lvl_q;
		if (in_data.gate) begin
			if (stage_q != STAGE_ATTACK && stage_q != STAGE_DECAY) begin
				stage_n = STAGE_ATTACK;
				lvl_s   = '0;
			end
			if (stage_n == STAGE_ATTACK && lvl_s == FULL)
				stage_n = STAGE_DECAY;
		end else begin
			stage_n = STAGE_RELEASE;
		end
	end

	assign dec_hold = SUS_W'(lvl_s) <= sus;

	always_comb begin
		if (stage_n == STAGE_ATTACK) begin
			mul_mc = NUM_W'(sample_rate);
			mul_mp = MP_W'(in_data.attack_time);
		end else if (stage_n == STAGE_DECAY) begin
			mul_mc = NUM_W'(lvl_s - sus[LVL_W-1:0]);
			mul_mp = MP_W'(in_data.decay_rate);
		end else begin
			mul_mc = NUM_W'(lvl_s);
			mul_mp = MP_W'(in_data.release_rate);
		end
	end

	// skip the arithmetic for an instant attack or a decay already at sustain
	assign mul_start = accept
		&& !(stage_n == STAGE_ATTACK && atk_zero)
		&& !(stage_n == STAGE_DECAY && dec_hold);

	assign div_start = (state_q == ST_MUL) && mul_done;

	always_comb begin
		if (stage_q == STAGE_ATTACK) begin
			div_num = NUM_W'(tick_divider) * ATK_SCALE;
			div_den = mul_prod[DEN_W-1:0];
		end else begin
			div_num = mul_prod;
			div_den = DEN_W'(PERMILLE);
		end
	end

	adsr_ser_mul #(.NUM_W(NUM_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mc     (mul_mc),
		.mp     (mul_mp),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	adsr_ser_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		atk_step = (step_q > FULL_N) ? FULL : step_q[LVL_W-1:0];
		atk_sum  = {1'b0, lvl_q} + {1'b0, atk_step};
		drop     = (step_q == '0) ? NUM_W'(1) : step_q;
		if (stage_q == STAGE_ATTACK)
			lvl_new = (atk_sum > {1'b0, FULL}) ? FULL : atk_sum[LVL_W-1:0];
		else if (hold_q)
			lvl_new = lvl_q;
		else if (drop >= NUM_W'(lvl_q))
			lvl_new = '0;
		else
			lvl_new = lvl_q - drop[LVL_W-1:0];
	end

	assign res_valid = (state_q == ST_FIN) && out_free;
	assign res_level = lvl_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= STAGE_RELEASE;
			lvl_q   <= '0;
			hold_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stage_q <= stage_n;
						lvl_q   <= lvl_s;
						hold_q  <= (stage_n == STAGE_DECAY) && dec_hold;
						state_q <= mul_start ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					if (mul_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						lvl_q   <= lvl_new;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// instant attack preloads a full-scale step; otherwise the quotient lands here
	always_ff @(posedge clk) begin
		if (accept)
			step_q <= FULL_N;
		else if (state_q == ST_DIV && div_done)
			step_q <= div_quot;
	end

	`ADSR_ASSERT_NEXT(a_one_tick, clk, arst_n, accept, !in_ready, "second request taken while busy")
	`ADSR_ASSERT_NEXT(a_atk_rise, clk, arst_n, res_valid && stage_q == STAGE_ATTACK, lvl_q >= $past(lvl_q), "attack lowered level")
	`ADSR_ASSERT_NEXT(a_dec_fall, clk, arst_n, res_valid && stage_q == STAGE_DECAY, lvl_q <= $past(lvl_q), "decay raised level")
	`ADSR_ASSERT_NEXT(a_rel_fall, clk, arst_n, res_valid && stage_q == STAGE_RELEASE, lvl_q == '0 || lvl_q < $past(lvl_q), "release did not drop")

endmodule

`default_nettype wire

// ===== src/adsr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope generator
// One envelope update per control tick, multiply/divide done bit-serially.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload  Notes
//  ctl      in   ctl_t    one request per control tick
//  env      out  env_t    new level, held in a one-deep output register
//  cfg      in   cfg_t    register write, always ready
//
//  A tick with arithmetic runs the shift-add multiplier and then the restoring
//  divider (NUM_W = 37) before the next request is accepted. An instant attack
//  or a held decay skips both and goes straight to the result.
//  Reset: stage release, level 0, sample_rate 44100, tick_divider 32.
//  A new request is taken while the previous result waits on env; its result
//  is held in the sequencer until env drains.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator import adsr_pkg::*; #(
	parameter int unsigned FULL_SCALE = 65535
) (
	input logic         clk,
	input logic         arst_n,
	adsr_chan_if.sink   ctl,
	adsr_chan_if.source env,
	adsr_chan_if.sink   cfg
);

	localparam int unsigned LVL_W = $clog2(FULL_SCALE + 1);

	logic [SR_W-1:0]  sample_rate_q;
	logic [TD_W-1:0]  tick_divider_q;
	logic             env_valid_q;
	logic [ENV_W-1:0] env_data_q;
	logic             out_free;
	logic             res_valid;
	logic [LVL_W-1:0] res_level;
	cfg_t             cfg_req;
	ctl_t             ctl_req;
	env_t             env_rsp;

	assign cfg_req   = cfg.payload;
	assign ctl_req   = ctl.payload;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q  <= SR_RESET;
			tick_divider_q <= TD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_req.index)
				REG_SAMPLE_RATE:  sample_rate_q  <= cfg_req.data[SR_W-1:0];
				REG_TICK_DIVIDER: tick_divider_q <= cfg_req.data[TD_W-1:0];
			endcase
		end
	end

	assign out_free = !env_valid_q || env.ready;

	adsr_ctrl #(
		.FULL_SCALE (FULL_SCALE),
		.LVL_W      (LVL_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (ctl.valid),
		.in_ready     (ctl.ready),
		.in_data      (ctl_req),
		.sample_rate  (sample_rate_q),
		.tick_divider (tick_divider_q),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res_level    (res_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			env_valid_q <= 1'b0;
		else if (res_valid)
			env_valid_q <= 1'b1;
		else if (env.ready)
			env_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			env_data_q <= ENV_W'(res_level);
	end

	assign env_rsp.envelope = env_data_q;
	assign env.valid        = env_valid_q;
	assign env.payload      = env_rsp;

endmodule

`default_nettype wire
